// ===== src/two_queue_position_merge_macros.svh =====
// Assertion helpers for the position merge block.
`ifndef TWO_QUEUE_POSITION_MERGE_MACROS_SVH
`define TWO_QUEUE_POSITION_MERGE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TQPM_ASSERT_COMB(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tqpm assertion failed");
`define TQPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tqpm assertion failed");
`else
`define TQPM_ASSERT_COMB(label, clk, rst_n, ante, cons)
`define TQPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/tqpm_pkg.sv =====
package tqpm_pkg;

  localparam int POS_W  = 31;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_SITE   = 3'd0,
    CMD_PUSH_INDEL  = 3'd1,
    CMD_FLUSH_BELOW = 3'd2,
    CMD_FLUSH_ALL   = 3'd3,
    CMD_DROP_SITES  = 3'd4,
    CMD_DROP_INDELS = 3'd5,
    CMD_CLEAR       = 3'd6
  } cmd_t;

  localparam logic STATUS_EMIT = 1'b0;
  localparam logic STATUS_DROP = 1'b1;
  localparam logic KIND_SITE   = 1'b0;
  localparam logic KIND_INDEL  = 1'b1;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] record_data;
    logic              erase_after;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              entry_kind;
    logic [POS_W-1:0]  entry_pos;
    logic [DATA_W-1:0] entry_data;
    logic              last_entry;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic mode_emit;
    logic mode_erase;
    logic mode_s_en;
    logic mode_i_en;
    logic push_site;
    logic push_indel;
    logic clear_all;
    logic pend_status;
    logic pend_kind;
    logic rd_en;
    logic rd_tail;
    logic set_stop_tail;
    logic take;
    logic finish;
  } tqpm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic site_full;
    logic indel_full;
    logic qualify;
    logic pend_v;
    logic emit;
    logic out_free;
  } tqpm_stat_t;

endpackage

// ===== src/tqpm_ctrl.sv =====
module tqpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tqpm_pkg::in_item_t   in_data,
  output tqpm_pkg::tqpm_cmd_t  cmd,
  input  tqpm_pkg::tqpm_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRD,
    S_TCALC,
    S_RD,
    S_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.cmd)
            tqpm_pkg::CMD_PUSH_SITE: begin
              if (stat.site_full) begin
                cmd.pend_status = 1'b1;
                cmd.pend_kind   = tqpm_pkg::KIND_SITE;
                state_nxt       = S_FIN;
              end else begin
                cmd.push_site = 1'b1;
              end
            end
            tqpm_pkg::CMD_PUSH_INDEL: begin
              if (stat.indel_full) begin
                cmd.pend_status = 1'b1;
                cmd.pend_kind   = tqpm_pkg::KIND_INDEL;
                state_nxt       = S_FIN;
              end else begin
                cmd.push_indel = 1'b1;
              end
            end
            tqpm_pkg::CMD_FLUSH_BELOW: begin
              cmd.start      = 1'b1;
              cmd.mode_emit  = 1'b1;
              cmd.mode_erase = in_data.erase_after;
              cmd.mode_s_en  = 1'b1;
              cmd.mode_i_en  = 1'b1;
              state_nxt      = S_RD;
            end
            tqpm_pkg::CMD_FLUSH_ALL: begin
              cmd.start      = 1'b1;
              cmd.mode_emit  = 1'b1;
              cmd.mode_erase = 1'b1;
              cmd.mode_s_en  = 1'b1;
              cmd.mode_i_en  = 1'b1;
              state_nxt      = S_TRD;
            end
            tqpm_pkg::CMD_DROP_SITES: begin
              cmd.start      = 1'b1;
              cmd.mode_erase = 1'b1;
              cmd.mode_s_en  = 1'b1;
              state_nxt      = S_RD;
            end
            tqpm_pkg::CMD_DROP_INDELS: begin
              cmd.start      = 1'b1;
              cmd.mode_erase = 1'b1;
              cmd.mode_i_en  = 1'b1;
              state_nxt      = S_RD;
            end
            tqpm_pkg::CMD_CLEAR: begin
              cmd.clear_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_TRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_tail = 1'b1;
        state_nxt   = S_TCALC;
      end
      S_TCALC: begin
        cmd.set_stop_tail = 1'b1;
        state_nxt         = S_RD;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!stat.qualify) begin
          state_nxt = S_FIN;
        end else if (!(stat.emit && stat.pend_v && !stat.out_free)) begin
          cmd.take  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (!stat.pend_v || stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tqpm_dp.sv =====
`include "two_queue_position_merge_macros.svh"

module tqpm_dp #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tqpm_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tqpm_pkg::out_item_t   out_data,
  input  tqpm_pkg::tqpm_cmd_t   cmd,
  output tqpm_pkg::tqpm_stat_t  stat
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int PW    = tqpm_pkg::POS_W;
  localparam int DW    = tqpm_pkg::DATA_W;
  localparam int REC_W = PW + DW;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[AW-1:0];
  endfunction

  logic [REC_W-1:0] site_mem  [QUEUE_DEPTH];
  logic [REC_W-1:0] indel_mem [QUEUE_DEPTH];
  logic [REC_W-1:0] site_rd_r, indel_rd_r;

  logic [AW-1:0] site_head_r, indel_head_r;
  logic [CW-1:0] site_cnt_r, indel_cnt_r;
  logic [CW-1:0] si_r, ii_r;
  logic [PW:0]   stop_r;
  logic          erase_r, emit_r, s_en_r, i_en_r;

  tqpm_pkg::out_item_t pend_r, out_r;
  logic                pend_v_r, out_valid_r, out_valid_nxt;

  logic [AW-1:0] site_wr_a, indel_wr_a;
  logic [AW-1:0] site_ra, indel_ra;
  logic [PW-1:0] s_pos, i_pos;
  logic [DW-1:0] s_dat, i_dat;
  logic          s_ok, i_ok, s_q, i_q, qualify, take_indel, move;
  logic [PW:0]   s_last, i_last;

  assign site_wr_a  = wrap(SW'(site_head_r) + SW'(site_cnt_r));
  assign indel_wr_a = wrap(SW'(indel_head_r) + SW'(indel_cnt_r));

  assign site_ra  = cmd.rd_tail ? wrap(SW'(site_head_r) + SW'(site_cnt_r - 1'b1))
                                : wrap(SW'(site_head_r) + SW'(si_r));
  assign indel_ra = cmd.rd_tail ? wrap(SW'(indel_head_r) + SW'(indel_cnt_r - 1'b1))
                                : wrap(SW'(indel_head_r) + SW'(ii_r));

  always_ff @(posedge clk) begin
    if (cmd.push_site) begin
      site_mem[site_wr_a] <= {in_data.position, in_data.record_data};
    end
    if (cmd.rd_en) begin
      site_rd_r <= site_mem[site_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_indel) begin
      indel_mem[indel_wr_a] <= {in_data.position, in_data.record_data};
    end
    if (cmd.rd_en) begin
      indel_rd_r <= indel_mem[indel_ra];
    end
  end

  assign s_pos = site_rd_r[REC_W-1 -: PW];
  assign s_dat = site_rd_r[DW-1:0];
  assign i_pos = indel_rd_r[REC_W-1 -: PW];
  assign i_dat = indel_rd_r[DW-1:0];

  assign s_ok       = s_en_r && (si_r < site_cnt_r);
  assign i_ok       = i_en_r && (ii_r < indel_cnt_r);
  assign s_q        = s_ok && ({1'b0, s_pos} < stop_r);
  assign i_q        = i_ok && ({1'b0, i_pos} < stop_r);
  assign qualify    = s_q || i_q;
  // indel wins ties
  assign take_indel = s_ok ? (i_ok && (s_pos >= i_pos)) : 1'b1;

  assign s_last = (site_cnt_r != '0) ? ({1'b0, s_pos} + 1'b1) : '0;
  assign i_last = (indel_cnt_r != '0) ? ({1'b0, i_pos} + 1'b1) : '0;

  assign move          = (cmd.take && emit_r && pend_v_r) || (cmd.finish && pend_v_r);
  assign out_valid_nxt = move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_head_r  <= '0;
      site_cnt_r   <= '0;
      indel_head_r <= '0;
      indel_cnt_r  <= '0;
      si_r         <= '0;
      ii_r         <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        site_head_r  <= '0;
        site_cnt_r   <= '0;
        indel_head_r <= '0;
        indel_cnt_r  <= '0;
      end else begin
        if (cmd.push_site) begin
          site_cnt_r <= site_cnt_r + 1'b1;
        end
        if (cmd.push_indel) begin
          indel_cnt_r <= indel_cnt_r + 1'b1;
        end
        if (cmd.finish && erase_r) begin
          site_head_r  <= wrap(SW'(site_head_r) + SW'(si_r));
          site_cnt_r   <= site_cnt_r - si_r;
          indel_head_r <= wrap(SW'(indel_head_r) + SW'(ii_r));
          indel_cnt_r  <= indel_cnt_r - ii_r;
        end
      end
      if (cmd.start || cmd.finish) begin
        si_r <= '0;
        ii_r <= '0;
      end else if (cmd.take) begin
        if (take_indel) begin
          ii_r <= ii_r + 1'b1;
        end else begin
          si_r <= si_r + 1'b1;
        end
      end
      if (cmd.pend_status || (cmd.take && emit_r)) begin
        pend_v_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_v_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stop_r  <= {1'b0, in_data.position};
      erase_r <= cmd.mode_erase;
      emit_r  <= cmd.mode_emit;
      s_en_r  <= cmd.mode_s_en;
      i_en_r  <= cmd.mode_i_en;
    end else if (cmd.set_stop_tail) begin
      stop_r <= (s_last > i_last) ? s_last : i_last;
    end else if (cmd.pend_status) begin
      erase_r <= 1'b0;
    end

    if (cmd.pend_status) begin
      pend_r.status      <= tqpm_pkg::STATUS_DROP;
      pend_r.entry_kind  <= cmd.pend_kind;
      pend_r.entry_pos   <= in_data.position;
      pend_r.entry_data  <= in_data.record_data;
      pend_r.last_entry  <= 1'b1;
    end else if (cmd.take && emit_r) begin
      pend_r.status      <= tqpm_pkg::STATUS_EMIT;
      pend_r.entry_kind  <= take_indel ? tqpm_pkg::KIND_INDEL : tqpm_pkg::KIND_SITE;
      pend_r.entry_pos   <= take_indel ? i_pos : s_pos;
      pend_r.entry_data  <= take_indel ? i_dat : s_dat;
      pend_r.last_entry  <= 1'b0;
    end

    if (move) begin
      out_r            <= pend_r;
      out_r.last_entry <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.site_full  = (site_cnt_r == DEPTH_C);
  assign stat.indel_full = (indel_cnt_r == DEPTH_C);
  assign stat.qualify    = qualify;
  assign stat.pend_v     = pend_v_r;
  assign stat.emit       = emit_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  `TQPM_ASSERT_COMB(a_walk_in_range, clk, rst_n, 1'b1, (si_r <= site_cnt_r) && (ii_r <= indel_cnt_r))
  `TQPM_ASSERT_NEXT(a_last_marked, clk, rst_n, cmd.finish && pend_v_r, out_valid_r && out_r.last_entry)
  `TQPM_ASSERT_NEXT(a_push_counts, clk, rst_n, cmd.push_site, site_cnt_r == $past(site_cnt_r) + 1'b1)
  `TQPM_ASSERT_COMB(a_no_overwrite, clk, rst_n, cmd.take && emit_r && pend_v_r, !out_valid_r || out_ready)

endmodule

// ===== src/two_queue_position_merge.sv =====
// Channel   Ports                          Moves
// --------  -----------------------------  ---------------------------------
// input     in_valid / in_ready / in_data  one command request per accept
// result    out_valid/out_ready/out_data   one emitted record or drop status
//
// Push, clear and unused codes complete in S_IDLE; a full-queue push also waits in S_FIN to send its drop status.
// Flush and drop walk each record through S_RD and S_CMP, then end in S_FIN (flush all
// first reads the tails in S_TRD and S_TCALC); reads use the registered read of each queue memory.
// Synchronous active-low reset empties both queues; stored entries are not cleared.
// A stalled result register holds the walk; in_ready is high only between commands.
module two_queue_position_merge #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tqpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tqpm_pkg::out_item_t out_data
);

  tqpm_pkg::tqpm_cmd_t  cmd;
  tqpm_pkg::tqpm_stat_t stat;

  tqpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat)
  );

  tqpm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== test/two_queue_position_merge_tb.sv =====
`timescale 1ns / 1ps

module two_queue_position_merge_tb;

  localparam int QUEUE_DEPTH = 32;
  localparam int PW = tqpm_pkg::POS_W;
  localparam int DW = tqpm_pkg::DATA_W;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [DW-1:0] data;
  } record_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tqpm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tqpm_pkg::out_item_t out_data;

  record_t             site_recs[$];
  record_t             indel_recs[$];
  tqpm_pkg::out_item_t due_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_rejects = 0;
  logic [PW-1:0] pos_cursor;

  two_queue_position_merge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void report_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // -------- predictor --------

  function automatic void trim_below(ref record_t recs[$], input logic [PW-1:0] stop);
    while (recs.size() > 0 && recs[0].pos < stop) void'(recs.pop_front());
  endfunction

  function automatic void merge_below(input logic [PW:0] stop, input logic erase);
    int si;
    int ii;
    int emitted;
    bit s_ok;
    bit i_ok;
    bit take_indel;
    tqpm_pkg::out_item_t r;
    si = 0;
    ii = 0;
    emitted = 0;
    while (1) begin
      s_ok = si < site_recs.size();
      i_ok = ii < indel_recs.size();
      if (!((s_ok && {1'b0, site_recs[si].pos} < stop) ||
            (i_ok && {1'b0, indel_recs[ii].pos} < stop))) break;
      take_indel = s_ok ? (i_ok && site_recs[si].pos >= indel_recs[ii].pos) : 1'b1;
      r.status = tqpm_pkg::STATUS_EMIT;
      r.last_entry = 1'b0;
      if (take_indel) begin
        r.entry_kind = tqpm_pkg::KIND_INDEL;
        r.entry_pos  = indel_recs[ii].pos;
        r.entry_data = indel_recs[ii].data;
        ii++;
      end else begin
        r.entry_kind = tqpm_pkg::KIND_SITE;
        r.entry_pos  = site_recs[si].pos;
        r.entry_data = site_recs[si].data;
        si++;
      end
      due_results.push_back(r);
      emitted++;
    end
    if (emitted > 0) begin
      r = due_results.pop_back();
      r.last_entry = 1'b1;
      due_results.push_back(r);
    end
    if (erase) begin
      repeat (si) void'(site_recs.pop_front());
      repeat (ii) void'(indel_recs.pop_front());
    end
  endfunction

  function automatic void push_record(ref record_t recs[$], input logic kind,
                                      input tqpm_pkg::in_item_t req);
    record_t rec;
    tqpm_pkg::out_item_t r;
    if (recs.size() >= QUEUE_DEPTH) begin
      r.status     = tqpm_pkg::STATUS_DROP;
      r.entry_kind = kind;
      r.entry_pos  = req.position;
      r.entry_data = req.record_data;
      r.last_entry = 1'b1;
      due_results.push_back(r);
      full_rejects++;
    end else begin
      rec.pos  = req.position;
      rec.data = req.record_data;
      recs.push_back(rec);
    end
  endfunction

  function automatic void predict_merge(input tqpm_pkg::in_item_t req);
    logic [PW:0] tail_s;
    logic [PW:0] tail_i;
    case (req.cmd)
      tqpm_pkg::CMD_PUSH_SITE:   push_record(site_recs, tqpm_pkg::KIND_SITE, req);
      tqpm_pkg::CMD_PUSH_INDEL:  push_record(indel_recs, tqpm_pkg::KIND_INDEL, req);
      tqpm_pkg::CMD_FLUSH_BELOW: merge_below({1'b0, req.position}, req.erase_after);
      tqpm_pkg::CMD_FLUSH_ALL: begin
        tail_s = '0;
        tail_i = '0;
        if (site_recs.size() > 0) tail_s = {1'b0, site_recs[$].pos} + 1'b1;
        if (indel_recs.size() > 0) tail_i = {1'b0, indel_recs[$].pos} + 1'b1;
        merge_below((tail_s > tail_i) ? tail_s : tail_i, 1'b1);
      end
      tqpm_pkg::CMD_DROP_SITES:  trim_below(site_recs, req.position);
      tqpm_pkg::CMD_DROP_INDELS: trim_below(indel_recs, req.position);
      tqpm_pkg::CMD_CLEAR: begin
        site_recs.delete();
        indel_recs.delete();
      end
      default: ;
    endcase
  endfunction

  // -------- result side --------

  always @(posedge clk) begin : result_check
    tqpm_pkg::out_item_t want;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (due_results.size() == 0) begin
        report_failure($sformatf(
          "unexpected result: st=%0d kind=%0d pos=%h data=%h last=%0d",
          out_data.status, out_data.entry_kind, out_data.entry_pos,
          out_data.entry_data, out_data.last_entry));
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status || out_data.entry_kind !== want.entry_kind ||
            out_data.entry_pos !== want.entry_pos ||
            out_data.entry_data !== want.entry_data ||
            out_data.last_entry !== want.last_entry) begin
          report_failure($sformatf(
            {"mismatch at %0t: exp st=%0d kind=%0d pos=%h data=%h last=%0d, ",
             "got st=%0d kind=%0d pos=%h data=%h last=%0d"},
            $time, want.status, want.entry_kind, want.entry_pos, want.entry_data,
            want.last_entry, out_data.status, out_data.entry_kind, out_data.entry_pos,
            out_data.entry_data, out_data.last_entry));
        end
      end
    end
  end

  // -------- request side --------

  task automatic send_request(input logic [2:0] code, input logic [PW-1:0] pos,
                              input logic [DW-1:0] data, input logic erase);
    tqpm_pkg::in_item_t req;
    int gap;
    req.cmd = code;
    req.position = pos;
    req.record_data = data;
    req.erase_after = erase;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_merge(req);
    requests_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // -------- tests --------

  task automatic test_merge_order();
    send_request(tqpm_pkg::CMD_PUSH_SITE, '0, '0, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_INDEL, '0, '1, 1'b1);
    send_request(tqpm_pkg::CMD_PUSH_SITE, 31'd5, 32'hA5A5_A5A5, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_INDEL, 31'd3, 32'h5A5A_5A5A, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_SITE, 31'd9, 32'h0000_0009, 1'b1);
    send_request(tqpm_pkg::CMD_PUSH_INDEL, 31'd9, 32'h8000_0009, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_BELOW, 31'd6, '0, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_BELOW, 31'd6, '1, 1'b1);
    send_request(tqpm_pkg::CMD_FLUSH_BELOW, '0, '0, 1'b1);
    wait_until_drained();
  endtask

  task automatic test_flush_all_edges();
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '0, '0, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '1, '1, 1'b1);
    send_request(tqpm_pkg::CMD_PUSH_SITE, '1, 32'hFFFF_0000, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_INDEL, 31'h7FFF_FFFE, 32'h0000_FFFF, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_BELOW, '1, '0, 1'b1);
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '0, '0, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '0, '0, 1'b0);
    wait_until_drained();
  endtask

  task automatic test_drop_and_clear();
    send_request(tqpm_pkg::CMD_PUSH_SITE, 31'd20, 32'h0000_0020, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_SITE, 31'd40, 32'h0000_0040, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_SITE, 31'd10, 32'h0000_0010, 1'b0);
    send_request(tqpm_pkg::CMD_PUSH_INDEL, 31'd15, 32'h8000_0015, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_BELOW, 31'd25, '0, 1'b0);
    send_request(tqpm_pkg::CMD_DROP_SITES, 31'd25, '0, 1'b1);
    send_request(tqpm_pkg::CMD_DROP_INDELS, 31'd16, '0, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '0, '0, 1'b1);
    send_request(CMD_UNUSED, '1, '1, 1'b1);
    send_request(tqpm_pkg::CMD_PUSH_INDEL, 31'd7, 32'h1234_5678, 1'b0);
    send_request(tqpm_pkg::CMD_CLEAR, '0, '0, 1'b0);
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '0, '0, 1'b0);
    wait_until_drained();
  endtask

  // receiver holds off while both queues overfill; rejects back up the input
  task automatic test_backpressure_fill();
    int k;
    logic [PW-1:0] base;
    base = PW'($urandom_range(32'h7000_0000, 32'h1000));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 600;
    for (k = 0; k <= QUEUE_DEPTH; k++) begin
      send_request(tqpm_pkg::CMD_PUSH_SITE, PW'(base + 2 * k), $urandom(), 1'b0);
    end
    for (k = 0; k <= QUEUE_DEPTH; k++) begin
      send_request(tqpm_pkg::CMD_PUSH_INDEL, PW'(base + 3 * k), $urandom(), 1'b0);
    end
    send_request(tqpm_pkg::CMD_FLUSH_ALL, '0, '0, 1'b0);
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int n;
    int pick;
    logic [DW-1:0] data;
    logic erase;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      data = $urandom();
      erase = 1'($urandom_range(1));
      if (pick < 32) begin
        send_request(tqpm_pkg::CMD_PUSH_SITE, pos_cursor, data, erase);
        pos_cursor = pos_cursor + PW'($urandom_range(2));
      end else if (pick < 64) begin
        send_request(tqpm_pkg::CMD_PUSH_INDEL, pos_cursor, data, erase);
        pos_cursor = pos_cursor + PW'($urandom_range(2));
      end else if (pick < 76) begin
        send_request(tqpm_pkg::CMD_FLUSH_BELOW, pos_cursor - PW'($urandom_range(12)),
                     data, erase);
      end else if (pick < 82) begin
        send_request(tqpm_pkg::CMD_FLUSH_ALL, PW'($urandom()), data, erase);
      end else if (pick < 86) begin
        send_request(tqpm_pkg::CMD_DROP_SITES, pos_cursor - PW'($urandom_range(12)),
                     data, erase);
      end else if (pick < 90) begin
        send_request(tqpm_pkg::CMD_DROP_INDELS, pos_cursor - PW'($urandom_range(12)),
                     data, erase);
      end else if (pick < 92) begin
        send_request(tqpm_pkg::CMD_CLEAR, PW'($urandom()), data, erase);
        pos_cursor = PW'($urandom_range(32'h7FFF_0000, 32'h100));
      end else if (pick < 94) begin
        send_request(CMD_UNUSED, PW'($urandom()), data, erase);
      end else if (pick < 97) begin
        send_request($urandom_range(1) ? tqpm_pkg::CMD_PUSH_INDEL : tqpm_pkg::CMD_PUSH_SITE,
                     PW'($urandom()), data, erase);
      end else begin
        send_request(tqpm_pkg::CMD_FLUSH_BELOW, PW'($urandom()), data, erase);
      end
    end
    wait_until_drained();
  endtask

  initial begin
    pos_cursor = PW'($urandom_range(32'h7FFF_0000, 32'h100));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_merge_order();
    test_flush_all_edges();
    test_drop_and_clear();
    test_backpressure_fill();
    test_random_traffic(0, 0, 21);
    test_random_traffic(50, 0, 21);
    test_random_traffic(0, 50, 21);
    test_random_traffic(27, 27, 21);

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests (pushes, merged flushes, drops, clears, unused codes),",
             requests_sent);
    $display("%0d full-queue rejects, %0d results checked under four idle/stall mixes %s%0d",
             full_rejects, results_checked, "plus a long receiver hold-off; errors: ",
             error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
